// File: design/dep_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Operation and status codes shared by the queue logic.
// ----------------------------------------------------------------------------
package dep_pkg;

   localparam logic [1:0] MODE_INSERT     = 2'd0;
   localparam logic [1:0] MODE_REMOVE_MIN = 2'd1;
   localparam logic [1:0] MODE_REMOVE_MAX = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// File: design/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Sorted circular store in one RAM with insertion by shifting.
// ----------------------------------------------------------------------------
// The values are kept in ascending order in a circular buffer in a single
// RAM; the smallest and largest values are also held in registers. Removing
// the smallest moves the head pointer, removing the largest shrinks the
// count, and either does one RAM read to refresh the bound, or none when it
// leaves the queue empty. An insert walks down from the top entry, moving each
// larger entry up one place, with a read and a write per moved entry through
// the RAM's one read and one write port, and then writes the new value into
// the gap. Other items go straight to the response. One item is in work at a
// time; the result waits in an output register until its transfer while the
// next item is already accepted and worked on.
module double_ended_priority_queue #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_max_value,
   output logic signed [31:0] rsp_min_value,
   output logic        rsp_is_empty,
   output logic [1:0]  rsp_status
);

   import dep_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;
   localparam int XW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef enum logic [2:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_RM_RD, S_RM_CAP, S_RSP
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  pos_ff, pos_in;
   val_type        key_ff, key_in;
   val_type        min_ff, min_in;
   val_type        max_ff, max_in;
   logic [1:0]     mode_ff, mode_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_max_ff, rsp_max_in;
   logic signed [31:0] rsp_min_ff, rsp_min_in;
   logic           rsp_empty_ff, rsp_empty_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   val_type        wr_data;
   logic [AW-1:0]  rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   val_type        rd_val;
   val_type        in_val;
   logic           accept;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(idx);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic signed [31:0] to_out(input val_type v);
      logic signed [XW-1:0] ext;
      ext = XW'(v);
      return ext[31:0];
   endfunction

   dep_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val    = val_type'(rd_data);
   assign in_val    = val_type'($unsigned(req_value));
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      mode_in       = mode_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, pos_ff);
      wr_data       = key_ff;
      rd_addr       = phys(head_ff, pos_ff - CW'(1));
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               key_in    = in_val;
               status_in = STATUS_DONE;
               state_in  = S_RSP;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = head_ff;
                        wr_data  = in_val;
                        min_in   = in_val;
                        max_in   = in_val;
                        count_in = CW'(1);
                     end else begin
                        if (in_val < min_ff) begin
                           min_in = in_val;
                        end
                        if (in_val > max_ff) begin
                           max_in = in_val;
                        end
                        pos_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  MODE_REMOVE_MIN, MODE_REMOVE_MAX: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (req_mode == MODE_REMOVE_MIN) begin
                           head_in = phys(head_ff, CW'(1));
                        end
                        if (count_ff != CW'(1)) begin
                           state_in = S_RM_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (rd_val > key_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_val;
               pos_in   = pos_ff - CW'(1);
               state_in = (pos_ff == CW'(1)) ? S_INS_WR : S_INS_RD;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = S_RSP;
         end
         S_RM_RD: begin
            rd_addr  = (mode_ff == MODE_REMOVE_MIN) ? head_ff
                                                    : phys(head_ff, count_ff - CW'(1));
            state_in = S_RM_CAP;
         end
         S_RM_CAP: begin
            if (mode_ff == MODE_REMOVE_MIN) begin
               min_in = rd_val;
            end else begin
               max_in = rd_val;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_empty_in  = (count_ff == '0);
               rsp_max_in    = (count_ff == '0) ? 32'sd0 : to_out(max_ff);
               rsp_min_in    = (count_ff == '0) ? 32'sd0 : to_out(min_ff);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("occupancy exceeds capacity");
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP && count_ff != '0) |-> (min_ff <= max_ff))
      else $error("smallest value above largest value");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted transfer left the queue idle");
   a_ins_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_RD) |-> (pos_ff != '0))
      else $error("insert walk passed the head");
`endif

endmodule

// File: design/dep_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/double_ended_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue testbench
// Drives inserts and removals through the request channel and checks each
// response against a sorted-list model of the queue, under varying idle and
// stall patterns, including a run that fills the store to capacity.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_test;
   import dep_pkg::*;

   localparam int CAPACITY   = 1024;
   localparam int SMALL_RUNS = 40;

   typedef struct packed {
      logic signed [31:0] max_value;
      logic signed [31:0] min_value;
      logic               is_empty;
      logic [1:0]         status;
   } queue_report_type;

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic               typed;
      queue_report_type   report;
   } stim_row_type;

   localparam logic [1:0] MODE_NONE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_INSERT;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_max_value;
   logic signed [31:0] rsp_min_value;
   logic               rsp_is_empty;
   logic [1:0]         rsp_status;

   int                 sorted_values[$];
   queue_report_type   pending_reports[$];
   int                 items_sent = 0;
   int                 reports_checked = 0;
   int                 full_drops = 0;
   int                 empty_removals = 0;
   int                 error_count = 0;
   int                 peak_fill = 0;
   int                 stall_left = 0;
   bit                 stall_done = 1'b0;

   always #5 clock = ~clock;

   double_ended_priority_queue i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_value (rsp_max_value),
      .rsp_min_value (rsp_min_value),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_status    (rsp_status)
   );

   function automatic int idle_percent(input bit receiver);
      int phase_sel;
      phase_sel = (items_sent / 64) % 4;
      case (phase_sel)
         1: begin
            return receiver ? 0 : 72;
         end
         2: begin
            return receiver ? 72 : 0;
         end
         3: begin
            return 18;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic queue_report_type apply_queue_item(input logic [1:0] mode,
                                                         input logic signed [31:0] value);
      queue_report_type report;
      int               pos;
      report.status = STATUS_DONE;
      if (mode == MODE_INSERT) begin
         if (sorted_values.size() >= CAPACITY) begin
            report.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_values.size() && sorted_values[pos] <= value) pos++;
            sorted_values.insert(pos, value);
         end
      end else if (mode == MODE_REMOVE_MIN || mode == MODE_REMOVE_MAX) begin
         if (sorted_values.size() == 0) begin
            report.status = STATUS_EMPTY;
         end else if (mode == MODE_REMOVE_MIN) begin
            void'(sorted_values.pop_front());
         end else begin
            void'(sorted_values.pop_back());
         end
      end
      if (sorted_values.size() == 0) begin
         report.max_value = '0;
         report.min_value = '0;
         report.is_empty  = 1'b1;
      end else begin
         report.max_value = sorted_values[$];
         report.min_value = sorted_values[0];
         report.is_empty  = 1'b0;
      end
      return report;
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic signed [31:0] value,
                            input bit typed, input queue_report_type typed_report);
      queue_report_type predicted;
      if ($urandom_range(99) < idle_percent(1'b0)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_percent(1'b0));
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = apply_queue_item(mode, value);
      pending_reports.push_back(typed ? typed_report : predicted);
      if (sorted_values.size() > peak_fill) peak_fill = sorted_values.size();
      if (predicted.status == STATUS_FULL) full_drops++;
      if (predicted.status == STATUS_EMPTY) empty_removals++;
      items_sent++;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: begin
            return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         end
         1: begin
            return $signed($urandom_range(8)) - 4;
         end
         2: begin
            return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                     : 32'sh80000000 + $urandom_range(3);
         end
         default: begin
            return $signed($urandom());
         end
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 47) return MODE_INSERT;
      if (roll < 71) return MODE_REMOVE_MIN;
      if (roll < 95) return MODE_REMOVE_MAX;
      return MODE_NONE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!stall_done && items_sent >= 300) begin
         stall_done <= 1'b1;
         stall_left <= 400;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_percent(1'b1));
      end
   end

   always @(posedge clock) begin
      queue_report_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: response transfer with none expected: max %0d min %0d", $time,
                     rsp_max_value, rsp_min_value);
            error_count++;
         end else begin
            wanted = pending_reports.pop_front();
            if (rsp_max_value !== wanted.max_value) begin
               $display("%0t: max_value expected %0d actual %0d", $time, wanted.max_value,
                        rsp_max_value);
               error_count++;
            end
            if (rsp_min_value !== wanted.min_value) begin
               $display("%0t: min_value expected %0d actual %0d", $time, wanted.min_value,
                        rsp_min_value);
               error_count++;
            end
            if (rsp_is_empty !== wanted.is_empty) begin
               $display("%0t: is_empty expected %0d actual %0d", $time, wanted.is_empty,
                        rsp_is_empty);
               error_count++;
            end
            if (rsp_status !== wanted.status) begin
               $display("%0t: status expected %0d actual %0d", $time, wanted.status,
                        rsp_status);
               error_count++;
            end
            reports_checked++;
         end
      end
   end

   initial begin
      #40_000_000;
      $display("double_ended_priority_queue_test failed");
      $finish;
   end

   initial begin
      stim_row_type     rows[$];
      queue_report_type none;
      int               ascend;
      none = '0;
      rows = '{
         '{MODE_REMOVE_MIN, 0,             1'b1, '{0, 0, 1'b1, STATUS_EMPTY}},
         '{MODE_REMOVE_MAX, 0,             1'b1, '{0, 0, 1'b1, STATUS_EMPTY}},
         '{MODE_NONE,       -1,            1'b1, '{0, 0, 1'b1, STATUS_DONE}},
         '{MODE_INSERT,     32'sh7fffffff, 1'b1,
           '{32'sh7fffffff, 32'sh7fffffff, 1'b0, STATUS_DONE}},
         '{MODE_INSERT,     32'sh80000000, 1'b1,
           '{32'sh7fffffff, 32'sh80000000, 1'b0, STATUS_DONE}},
         '{MODE_INSERT,     0,             1'b0, none},
         '{MODE_INSERT,     -1,            1'b0, none},
         '{MODE_INSERT,     -1,            1'b0, none},
         '{MODE_INSERT,     32'sh80000000, 1'b0, none},
         '{MODE_INSERT,     5,             1'b0, none},
         '{MODE_NONE,       0,             1'b0, none},
         '{MODE_REMOVE_MIN, 0,             1'b0, none},
         '{MODE_REMOVE_MIN, 0,             1'b0, none},
         '{MODE_REMOVE_MAX, 0,             1'b0, none},
         '{MODE_REMOVE_MIN, 0,             1'b0, none},
         '{MODE_REMOVE_MAX, 0,             1'b0, none},
         '{MODE_REMOVE_MIN, 0,             1'b0, none},
         '{MODE_REMOVE_MAX, 32'sh7fffffff, 1'b0, none},
         '{MODE_REMOVE_MIN, 0,             1'b1, '{0, 0, 1'b1, STATUS_EMPTY}}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_item(rows[i].mode, rows[i].value, rows[i].typed, rows[i].report);
      repeat (SMALL_RUNS) send_item(pick_mode(), pick_value(), 1'b0, none);
      // Mostly ascending inserts keep the shifting short while the store fills up.
      ascend = 1000;
      while (sorted_values.size() < CAPACITY) begin
         ascend += $urandom_range(3);
         send_item(MODE_INSERT, ($urandom_range(15) == 0) ? pick_value() : ascend, 1'b0, none);
      end
      repeat (4) send_item(MODE_INSERT, pick_value(), 1'b0, none);
      repeat (40) send_item(($urandom_range(3) == 0) ? MODE_INSERT :
                            ($urandom_range(1) ? MODE_REMOVE_MIN : MODE_REMOVE_MAX),
                            $signed($urandom()), 1'b0, none);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d items, checked %0d responses, peak fill %0d of %0d.",
               items_sent, reports_checked, peak_fill, CAPACITY);
      $display("Full-store drops %0d, removals on empty %0d, mismatches %0d.",
               full_drops, empty_removals, error_count);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("double_ended_priority_queue_test passed");
      end else begin
         $display("double_ended_priority_queue_test failed");
      end
      $finish;
   end

endmodule
